/* design/assert_macros.svh */
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);

`endif

/* design/mes_pkg.sv */
`timescale 1ns / 1ps
package mes_pkg;

  // Input action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_MSG   = 2'd1;
  localparam logic [1:0] ACT_PANIC = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_DELAY  = 3'd0;
  localparam logic [2:0] REG_REPEAT = 3'd1;
  localparam logic [2:0] REG_DECAY  = 3'd2;
  localparam logic [2:0] REG_SHIFT  = 3'd3;
  localparam logic [2:0] REG_BYPASS = 3'd4;

  // Register reset values
  localparam logic [15:0] DELAY_RST  = 16'd5512;
  localparam logic [3:0]  REPEAT_RST = 4'd3;
  localparam logic [9:0]  DECAY_RST  = 10'd166;

  localparam logic [15:0] MIN_DELAY   = 16'd50;
  localparam logic [15:0] VEL_FLOOR   = 16'd1280;   // 5.0 in Q8.8
  localparam logic [15:0] VEL_CEIL    = 16'd32512;  // 127.0 in Q8.8
  localparam logic [9:0]  DECAY_UNITY = 10'd256;
  localparam logic [3:0]  NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0]  NIB_NOTE_OFF = 4'h8;

  localparam int DLY_W = 21;

  // One pool entry
  typedef struct packed {
    logic [3:0]              chan;
    logic [6:0]              note;
    logic [6:0]              vel;
    logic                    on;
    logic signed [DLY_W-1:0] dly;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [11:0] pos;
    logic        drop;
    logic        last;
  } beat_t;

  // Per-tap velocity and pitch results
  typedef struct packed {
    logic              stop;
    logic [15:0]       v_next;
    logic signed [8:0] pitch_next;
    logic [6:0]        note;
    logic [6:0]        vel;
  } tap_t;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_TAP       = 7'b0000010,
    S_OFF       = 7'b0000100,
    S_MSG_OUT   = 7'b0001000,
    S_WALK_RD   = 7'b0010000,
    S_WALK_PROC = 7'b0100000,
    S_WALK_END  = 7'b1000000
  } state_t;

endpackage

/* design/mes_tap.sv */
`timescale 1ns / 1ps
// Velocity decay and pitch step for one echo tap
module mes_tap (
  input  logic [15:0]       v,
  input  logic [9:0]        decay,
  input  logic signed [8:0] pitch,
  input  logic signed [4:0] shift,
  output mes_pkg::tap_t     tap
);

  logic [25:0] prod;
  logic [17:0] vn;
  logic [15:0] vc;
  logic [15:0] vr;
  logic [7:0]  ov;

  always_comb begin
    // Q8.8 multiply, rounded half up; the product can exceed 16 bits before the clamp
    prod = 26'(v) * 26'(decay) + 26'd128;
    vn   = prod[25:8];
    vc   = (vn > 18'(mes_pkg::VEL_CEIL)) ? mes_pkg::VEL_CEIL : vn[15:0];
    tap.stop   = (decay <= mes_pkg::DECAY_UNITY) && (vn < 18'(mes_pkg::VEL_FLOOR));
    tap.v_next = vc;
    // Output velocity limited to 1..127
    vr = vc + 16'd128;
    ov = vr[15:8];
    if (ov == 8'd0)       tap.vel = 7'd1;
    else if (ov > 8'd127) tap.vel = 7'd127;
    else                  tap.vel = ov[6:0];
    // Pitch accumulates unclamped; the note is clamped
    tap.pitch_next = pitch + 9'(shift);
    if (tap.pitch_next < 0)           tap.note = 7'd0;
    else if (tap.pitch_next > 9'sd127) tap.note = 7'd127;
    else                              tap.note = tap.pitch_next[6:0];
  end

endmodule

/* design/midi_echo_scheduler.sv */
`timescale 1ns / 1ps
// MIDI echo scheduler.
// in_*: one beat per input item; in_tuser is the action (tick, message, panic),
// in_tdata the message, its position and the tick's block length.
// out_*: result beats; out_tlast marks the final beat of an input item,
// out_tuser flags a pass-through whose note-on lost echoes to a full pool.
// cfg_*: register writes by index, always ready; write only while idle.
// An input is taken only while the scheduler is idle. A message makes two pool
// writes per echo tap, one at a time through the single write port.
// A tick (outside bypass) or panic walks the pool, with a memory read and then
// a decide and write back for each pending entry.
// Due entries are held one beat back so that the last one can carry tlast.
// Reset clears the pool count, the configuration registers and the handshakes; pool memory
// needs no clearing since only entries below the count are read.
// A stalled receiver freezes the walk at the next beat it must emit; the
// single output register keeps its beat until taken.
module midi_echo_scheduler #(
  parameter int POOL_ENTRIES      = 64,
  parameter int MAX_BLOCK_SAMPLES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // msg_status, msg_data1, msg_data2, position, block_samples
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_status, out_data1, out_data2, out_position
  output logic        out_tuser,  // echoes_dropped
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int DW = mes_pkg::DLY_W;

  // Configuration registers
  logic [15:0]       delay_r;
  logic [3:0]        repeat_r;
  logic [9:0]        decay_r;
  logic signed [4:0] shift_r;
  logic              bypass_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= mes_pkg::DELAY_RST;
      repeat_r <= mes_pkg::REPEAT_RST;
      decay_r  <= mes_pkg::DECAY_RST;
      shift_r  <= 5'sd0;
      bypass_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mes_pkg::REG_DELAY:  delay_r  <= cfg_data;
        mes_pkg::REG_REPEAT: repeat_r <= cfg_data[3:0];
        mes_pkg::REG_DECAY:  decay_r  <= cfg_data[9:0];
        mes_pkg::REG_SHIFT:  shift_r  <= cfg_data[4:0];
        mes_pkg::REG_BYPASS: bypass_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [7:0]  f_status;
  logic [6:0]  f_data1;
  logic [6:0]  f_data2;
  logic [11:0] f_pos;
  logic [12:0] f_blk;
  assign f_status = in_tdata[7:0];
  assign f_data1  = in_tdata[14:8];
  assign f_data2  = in_tdata[21:15];
  assign f_pos    = in_tdata[33:22];
  assign f_blk    = in_tdata[46:34];

  logic [15:0] d_eff;
  assign d_eff = (delay_r < mes_pkg::MIN_DELAY) ? mes_pkg::MIN_DELAY : delay_r;

  // State
  mes_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     keep_r, keep_nxt;
  logic              tick_r, tick_nxt;
  logic [7:0]        st_r, st_nxt;
  logic [6:0]        d1_r, d1_nxt;
  logic [6:0]        d2_r, d2_nxt;
  logic [11:0]       pos_r, pos_nxt;
  logic [12:0]       blk_r, blk_nxt;
  logic              drop_r, drop_nxt;
  logic [15:0]       v_r, v_nxt;
  logic signed [8:0] pitch_r, pitch_nxt;
  logic [6:0]        note_r, note_nxt;
  logic [19:0]       on_at_r, on_at_nxt;
  logic [3:0]        r_r, r_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  mes_pkg::beat_t    hold_r, hold_nxt;
  logic              out_valid_r, out_valid_nxt;
  mes_pkg::beat_t    out_r, out_nxt;

  // Pool memory
  mes_pkg::entry_t pool_mem [POOL_ENTRIES];
  mes_pkg::entry_t rd_data_r;
  logic            rd_en;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  mes_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) pool_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= pool_mem[idx_r[AW-1:0]];
  end

  mes_pkg::tap_t tap;
  mes_tap u_tap (
    .v     (v_r),
    .decay (decay_r),
    .pitch (pitch_r),
    .shift (shift_r),
    .tap   (tap)
  );

  logic                 can_push;
  logic                 in_fire;
  logic [CW:0]          room;
  logic signed [DW-1:0] blk_s;
  logic signed [DW-1:0] dn;
  logic                 due;
  logic [12:0]          blk_m1;
  logic [11:0]          epos;
  mes_pkg::beat_t       ebeat;
  logic                 note_on;

  assign can_push  = !out_valid_r || out_tready;
  assign in_tready = (state_r == mes_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign note_on   = !bypass_r && (f_status[7:4] == mes_pkg::NIB_NOTE_ON) && (f_data2 != 7'd0);

  // Entry evaluation during the walk
  always_comb begin
    room   = {1'b0, count_r} + (CW+1)'(2);
    blk_s  = DW'(signed'({1'b0, blk_r}));
    dn     = rd_data_r.dly - blk_s;
    due    = tick_r ? (dn <= 0) : rd_data_r.on;
    blk_m1 = blk_r - 13'd1;
    if (rd_data_r.dly < 0)                              epos = 12'd0;
    else if (rd_data_r.dly > DW'(signed'({1'b0, blk_m1}))) epos = blk_m1[11:0];
    else                                                epos = rd_data_r.dly[11:0];
    ebeat.status = {(tick_r && rd_data_r.on) ? mes_pkg::NIB_NOTE_ON : mes_pkg::NIB_NOTE_OFF,
                    rd_data_r.chan};
    ebeat.data1  = rd_data_r.note;
    ebeat.data2  = (tick_r && rd_data_r.on) ? rd_data_r.vel : 7'd0;
    ebeat.pos    = tick_r ? epos : 12'd0;
    ebeat.drop   = 1'b0;
    ebeat.last   = 1'b0;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    tick_nxt       = tick_r;
    st_nxt         = st_r;
    d1_nxt         = d1_r;
    d2_nxt         = d2_r;
    pos_nxt        = pos_r;
    blk_nxt        = blk_r;
    drop_nxt       = drop_r;
    v_nxt          = v_r;
    pitch_nxt      = pitch_r;
    note_nxt       = note_r;
    on_at_nxt      = on_at_r;
    r_nxt          = r_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = '0;

    unique case (state_r)
      mes_pkg::S_IDLE: begin
        if (in_fire) begin
          st_nxt    = f_status;
          d1_nxt    = f_data1;
          d2_nxt    = f_data2;
          pos_nxt   = f_pos;
          drop_nxt  = 1'b0;
          idx_nxt   = '0;
          keep_nxt  = '0;
          v_nxt     = {1'b0, f_data2, 8'd0};
          pitch_nxt = 9'(signed'({2'b00, f_data1}));
          on_at_nxt = 20'(f_pos) + 20'(d_eff);
          r_nxt     = 4'd1;
          // Block length limited to 1..MAX_BLOCK_SAMPLES
          if (f_blk == 13'd0)                          blk_nxt = 13'd1;
          else if (f_blk > 13'(MAX_BLOCK_SAMPLES))     blk_nxt = 13'(MAX_BLOCK_SAMPLES);
          else                                         blk_nxt = f_blk;
          priority case (in_tuser)
            mes_pkg::ACT_TICK: begin
              tick_nxt = 1'b1;
              if (!bypass_r) state_nxt = mes_pkg::S_WALK_RD;
            end
            mes_pkg::ACT_MSG: begin
              if (note_on && repeat_r != 4'd0) state_nxt = mes_pkg::S_TAP;
              else                             state_nxt = mes_pkg::S_MSG_OUT;
            end
            mes_pkg::ACT_PANIC: begin
              tick_nxt  = 1'b0;
              state_nxt = mes_pkg::S_WALK_RD;
            end
            default: ;
          endcase
        end
      end

      // Note-on half of a tap
      mes_pkg::S_TAP: begin
        if (tap.stop) begin
          state_nxt = mes_pkg::S_MSG_OUT;
        end else if (room > (CW+1)'(POOL_ENTRIES)) begin
          drop_nxt  = 1'b1;
          state_nxt = mes_pkg::S_MSG_OUT;
        end else begin
          wr_en        = 1'b1;
          wr_data.chan = st_r[3:0];
          wr_data.note = tap.note;
          wr_data.vel  = tap.vel;
          wr_data.on   = 1'b1;
          wr_data.dly  = DW'(signed'({1'b0, on_at_r}));
          count_nxt    = count_r + CW'(1);
          v_nxt        = tap.v_next;
          pitch_nxt    = tap.pitch_next;
          note_nxt     = tap.note;
          state_nxt    = mes_pkg::S_OFF;
        end
      end

      // Note-off half, half a delay later
      mes_pkg::S_OFF: begin
        wr_en        = 1'b1;
        wr_data.chan = st_r[3:0];
        wr_data.note = note_r;
        wr_data.vel  = 7'd0;
        wr_data.on   = 1'b0;
        wr_data.dly  = DW'(signed'({1'b0, on_at_r})) + DW'(signed'({1'b0, d_eff[15:1]}));
        count_nxt    = count_r + CW'(1);
        on_at_nxt    = on_at_r + 20'(d_eff);
        if (r_r == repeat_r) begin
          state_nxt = mes_pkg::S_MSG_OUT;
        end else begin
          r_nxt     = r_r + 4'd1;
          state_nxt = mes_pkg::S_TAP;
        end
      end

      mes_pkg::S_MSG_OUT: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          out_nxt.status = st_r;
          out_nxt.data1  = d1_r;
          out_nxt.data2  = d2_r;
          out_nxt.pos    = pos_r;
          out_nxt.drop   = drop_r;
          out_nxt.last   = 1'b1;
          state_nxt      = mes_pkg::S_IDLE;
        end
      end

      mes_pkg::S_WALK_RD: begin
        if (idx_r == count_r) begin
          state_nxt = mes_pkg::S_WALK_END;
        end else begin
          rd_en     = 1'b1;
          state_nxt = mes_pkg::S_WALK_PROC;
        end
      end

      mes_pkg::S_WALK_PROC: begin
        if (due) begin
          if (!hold_valid_r || can_push) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = hold_r;
            end
            hold_valid_nxt = 1'b1;
            hold_nxt       = ebeat;
            idx_nxt        = idx_r + CW'(1);
            state_nxt      = mes_pkg::S_WALK_RD;
          end
        end else begin
          // Compact surviving entries toward the front
          if (tick_r) begin
            wr_en       = 1'b1;
            wr_addr     = keep_r[AW-1:0];
            wr_data     = rd_data_r;
            wr_data.dly = dn;
            keep_nxt    = keep_r + CW'(1);
          end
          idx_nxt   = idx_r + CW'(1);
          state_nxt = mes_pkg::S_WALK_RD;
        end
      end

      mes_pkg::S_WALK_END: begin
        if (!hold_valid_r || can_push) begin
          if (hold_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = hold_r;
            out_nxt.last  = 1'b1;
          end
          hold_valid_nxt = 1'b0;
          count_nxt      = tick_r ? keep_r : '0;
          state_nxt      = mes_pkg::S_IDLE;
        end
      end

      default: state_nxt = mes_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mes_pkg::S_IDLE;
      count_r      <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    keep_r  <= keep_nxt;
    tick_r  <= tick_nxt;
    st_r    <= st_nxt;
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    pos_r   <= pos_nxt;
    blk_r   <= blk_nxt;
    drop_r  <= drop_nxt;
    v_r     <= v_nxt;
    pitch_r <= pitch_nxt;
    note_r  <= note_nxt;
    on_at_r <= on_at_nxt;
    r_r     <= r_nxt;
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.pos, out_r.data2, out_r.data1, out_r.status};
  assign out_tuser  = out_r.drop;
  assign out_tlast  = out_r.last;

`include "assert_macros.svh"

  `ASSERT_IMP(a_count_fits, clk, rst_n, 1'b1, count_r <= CW'(POOL_ENTRIES),
              "pool count overflow")
  `ASSERT_IMP(a_idle_no_hold, clk, rst_n, state_r == mes_pkg::S_IDLE, !hold_valid_r,
              "held beat lost at idle")
  `ASSERT_IMP(a_keep_behind, clk, rst_n, state_r == mes_pkg::S_WALK_PROC,
              keep_r <= idx_r && idx_r < count_r, "compaction overtook walk")
  `ASSERT_NEXT(a_tap_write, clk, rst_n,
               state_r == mes_pkg::S_TAP && state_nxt == mes_pkg::S_OFF,
               count_r < CW'(POOL_ENTRIES), "note-off written past pool end")

endmodule
